[sv/lru_fr_pkg.sv]
// ----------------------------------------------------------------------------
// lru_fr_pkg
// shared constants and types for the lru frame replacer
// ----------------------------------------------------------------------------
package lru_fr_pkg;

  localparam int unsigned FramesDef = 64;  // default number of frames
  localparam int unsigned FrameW    = 6;   // width of a frame number field
  localparam int unsigned CountW    = 7;   // width of the set size field
  localparam int unsigned ActionW   = 2;   // width of the action code

  // action codes, the fourth code is a no-op
  localparam logic [ActionW-1:0] ActEvict = 2'd0;
  localparam logic [ActionW-1:0] ActPin   = 2'd1;
  localparam logic [ActionW-1:0] ActUnpin = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

[sv/lru_frame_replacer.sv]
// ----------------------------------------------------------------------------
// lru_frame_replacer
// lru set of evictable frames kept as a doubly linked list in two link rams
// ----------------------------------------------------------------------------
//
// channel  dir  tdata (low bit up)                 tuser
// s_axis   in   frame[5:0], zero pad [7:6]         action[1:0]
// m_axis   out  victim_frame[5:0],                 ok[0]
//               evictable_count[12:6], pad [15:13]
//
// each item passes through idle and exec: the accept cycle in idle issues the
//   reads of the next and prev link rams, the exec state uses the read data,
//   writes each ram at most once and loads the output register
// the link rams have one write and one read port each; a stalled output
//   holds the exec state, and no new item is accepted while in it
// reset clears the membership flops, the list ends and the set size; the
//   link rams are not cleared
// frames at or above FRAMES are ignored by pin and unpin
//
module lru_frame_replacer #(
  parameter int unsigned FRAMES = lru_fr_pkg::FramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] frame, [7:6] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] victim_frame, [12:6] evictable_count
  output logic        m_axis_tuser    // [0] ok
);

  // only frame numbers that fit the frame field can ever join the set
  localparam int unsigned MaxFrames = 1 << lru_fr_pkg::FrameW;
  localparam int unsigned Depth     = (FRAMES < MaxFrames) ? FRAMES : MaxFrames;
  localparam int unsigned IdxW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW      = $clog2(Depth + 1);

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  lru_fr_pkg::state_e state_q, state_d;

  // item held for the exec state
  logic [lru_fr_pkg::ActionW-1:0] act_q;
  idx_t                           frm_q;
  logic                           in_range_q;

  // list ends and size
  idx_t oldest_q, oldest_d;
  idx_t newest_q, newest_d;
  cnt_t size_q, size_d;
  logic [Depth-1:0] member_q, member_d;

  // link rams
  idx_t next_mem [Depth];
  idx_t prev_mem [Depth];
  idx_t rd_addr;
  idx_t next_rd_q, prev_rd_q;
  logic next_we, prev_we;
  idx_t next_waddr, next_wdata, prev_waddr, prev_wdata;

  // output register
  logic                           out_valid_q;
  logic                           out_ok_q;
  logic [lru_fr_pkg::FrameW-1:0]  out_victim_q;
  logic [lru_fr_pkg::CountW-1:0]  out_count_q;

  logic in_fire, out_free, done;
  logic in_range;
  logic [lru_fr_pkg::ActionW-1:0] in_act;
  logic [lru_fr_pkg::FrameW-1:0]  in_frame;
  logic is_member, do_unlink, do_append, evict_hit;

  assign in_act   = s_axis_tuser;
  assign in_frame = s_axis_tdata[lru_fr_pkg::FrameW-1:0];
  assign in_range = ({1'b0, in_frame} < (lru_fr_pkg::FrameW + 1)'(Depth));

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign done     = (state_q == lru_fr_pkg::ST_EXEC) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lru_fr_pkg::ST_IDLE: begin
        if (in_fire) state_d = lru_fr_pkg::ST_EXEC;
      end
      lru_fr_pkg::ST_EXEC: begin
        if (out_free) state_d = lru_fr_pkg::ST_IDLE;
      end
      default: state_d = lru_fr_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    case (state_q)
      lru_fr_pkg::ST_IDLE: s_axis_tready = 1'b1;
      lru_fr_pkg::ST_EXEC: s_axis_tready = 1'b0;
      default:             s_axis_tready = 1'b0;
    endcase
  end

  // read address: the oldest frame on evict, else the named frame
  always_comb begin
    if (state_q == lru_fr_pkg::ST_IDLE) begin
      rd_addr = (in_act == lru_fr_pkg::ActEvict) ? oldest_q : in_frame[IdxW-1:0];
    end else begin
      rd_addr = frm_q;
    end
  end

  // list update in the exec state, next_rd_q and prev_rd_q are the read links of frm_q
  always_comb begin
    is_member = member_q[frm_q];
    evict_hit = (act_q == lru_fr_pkg::ActEvict) && (size_q != '0);
    do_unlink = evict_hit ||
                ((act_q == lru_fr_pkg::ActPin) && in_range_q && is_member);
    do_append = (act_q == lru_fr_pkg::ActUnpin) && in_range_q && !is_member;

    oldest_d   = oldest_q;
    newest_d   = newest_q;
    size_d     = size_q;
    member_d   = member_q;
    next_we    = 1'b0;
    next_waddr = prev_rd_q;
    next_wdata = next_rd_q;
    prev_we    = 1'b0;
    prev_waddr = next_rd_q;
    prev_wdata = prev_rd_q;

    if (do_unlink) begin
      // bypass the frame on both sides, or move a list end
      if (frm_q == oldest_q) oldest_d = next_rd_q;
      else                   next_we  = 1'b1;
      if (frm_q == newest_q) newest_d = prev_rd_q;
      else                   prev_we  = 1'b1;
      member_d[frm_q] = 1'b0;
      size_d          = size_q - cnt_t'(1);
    end else if (do_append) begin
      if (size_q == '0) begin
        oldest_d = frm_q;
      end else begin
        // hook behind the current newest frame
        next_we    = 1'b1;
        next_waddr = newest_q;
        next_wdata = frm_q;
        prev_we    = 1'b1;
        prev_waddr = frm_q;
        prev_wdata = newest_q;
      end
      newest_d        = frm_q;
      member_d[frm_q] = 1'b1;
      size_d          = size_q + cnt_t'(1);
    end
  end

  // link rams, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (done && next_we) next_mem[next_waddr] <= next_wdata;
    next_rd_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (done && prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_rd_q <= prev_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lru_fr_pkg::ST_IDLE;
      oldest_q    <= '0;
      newest_q    <= '0;
      size_q      <= '0;
      member_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done) begin
        oldest_q <= oldest_d;
        newest_q <= newest_d;
        size_q   <= size_d;
        member_q <= member_d;
      end
      if (done)               out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q      <= in_act;
      frm_q      <= rd_addr;
      in_range_q <= in_range;
    end
    if (done) begin
      out_ok_q     <= evict_hit;
      out_victim_q <= evict_hit ? lru_fr_pkg::FrameW'(frm_q) : '0;
      out_count_q  <= lru_fr_pkg::CountW'(size_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_victim_q};

endmodule

[verif/lru_frame_replacer_test.sv]
// ----------------------------------------------------------------------------
// lru_frame_replacer_test
// self-checking bench for the lru frame replacer: a bursty driver feeds
// evict, pin, unpin and no-op items, a scoreboard model of the linked list
// predicts every result, and a monitor behind a stalling receiver compares
// each result item field by field
// ----------------------------------------------------------------------------
module lru_frame_replacer_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Frames    = lru_fr_pkg::FramesDef;
  localparam logic [lru_fr_pkg::ActionW-1:0] ActNop = 2'd3;  // undefined code, no effect
  localparam int unsigned RandItems = 1650;      // random items that do work
  localparam int unsigned IdleLimit = 4000;      // cycles without any handshake
  localparam int unsigned DrainWait = 16;        // settle cycles at the end

  typedef struct packed {
    logic [lru_fr_pkg::ActionW-1:0] action;
    logic [lru_fr_pkg::FrameW-1:0]  frame;
  } lru_req_t;

  typedef struct packed {
    logic                          ok;
    logic [lru_fr_pkg::FrameW-1:0] victim;
    logic [lru_fr_pkg::CountW-1:0] count;
  } lru_rsp_t;

  // dut ports; the inputs are known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  lru_frame_replacer #(
    .FRAMES(Frames)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [5:0] frame, [7:6] zero
    .s_axis_tuser (s_axis_tuser),   // [1:0] action
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [5:0] victim_frame, [12:6] evictable_count
    .m_axis_tuser (m_axis_tuser)    // [0] ok
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // scoreboard model of the replacer: membership bits, link arrays, list ends
  // ---------------------------------------------------------------------------
  logic                          in_set   [Frames];
  logic [lru_fr_pkg::FrameW-1:0] link_nxt [Frames];
  logic [lru_fr_pkg::FrameW-1:0] link_prv [Frames];
  logic [lru_fr_pkg::FrameW-1:0] lru_head = '0;   // oldest frame
  logic [lru_fr_pkg::FrameW-1:0] lru_tail = '0;   // newest frame
  logic [lru_fr_pkg::CountW-1:0] lru_size = '0;

  initial begin
    for (int i = 0; i < Frames; i++) begin
      in_set[i]   = 1'b0;
      link_nxt[i] = '0;
      link_prv[i] = '0;
    end
  end

  // take a member frame out of the list, patching its neighbors
  function automatic void drop_frame(logic [lru_fr_pkg::FrameW-1:0] f);
    logic [lru_fr_pkg::FrameW-1:0] n;
    logic [lru_fr_pkg::FrameW-1:0] p;
    n = link_nxt[f];
    p = link_prv[f];
    if (f == lru_head) lru_head = n;
    else link_nxt[p] = n;
    if (f == lru_tail) lru_tail = p;
    else link_prv[n] = p;
    in_set[f] = 1'b0;
    lru_size  = lru_size - 1'b1;
  endfunction

  // hang an absent frame on the newest end
  function automatic void join_frame(logic [lru_fr_pkg::FrameW-1:0] f);
    if (lru_size == 0) begin
      lru_head = f;
      lru_tail = f;
    end else begin
      link_nxt[lru_tail] = f;
      link_prv[f]        = lru_tail;
      lru_tail           = f;
    end
    link_nxt[f] = f;
    in_set[f]   = 1'b1;
    lru_size    = lru_size + 1'b1;
  endfunction

  // apply one item to the model and return the result it produces
  function automatic lru_rsp_t replace_step(lru_req_t r);
    lru_rsp_t rsp;
    rsp = '0;
    case (r.action)
      lru_fr_pkg::ActEvict: begin
        if (lru_size != 0) begin
          rsp.ok     = 1'b1;
          rsp.victim = lru_head;
          drop_frame(lru_head);
        end
      end
      lru_fr_pkg::ActPin: begin
        if (in_set[r.frame]) drop_frame(r.frame);
      end
      lru_fr_pkg::ActUnpin: begin
        if (!in_set[r.frame]) join_frame(r.frame);
      end
      default: ;
    endcase
    rsp.count = lru_size;
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus queue and expected results, each read through its own index
  // ---------------------------------------------------------------------------
  lru_req_t pending_q[$];
  lru_rsp_t expected_q[$];
  int unsigned pend_rd = 0;
  int unsigned exp_rd = 0;
  int unsigned errors = 0;

  function automatic void queue_item(logic [lru_fr_pkg::ActionW-1:0] a,
                                     logic [lru_fr_pkg::FrameW-1:0] f);
    lru_req_t r;
    r.action = a;
    r.frame  = f;
    pending_q.insert(pending_q.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  lru_req_t    cur_req = '0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    logic taken;
    taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      // the model advances on the item that was just accepted
      if (taken) expected_q.insert(expected_q.size(), replace_step(cur_req));
      if (s_axis_tvalid && !taken) begin
        // hold the offered item until it is accepted
      end else if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (pend_rd < pending_q.size()) begin
        cur_req       = pending_q[pend_rd];
        pend_rd++;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, cur_req.frame};
        s_axis_tuser  <= cur_req.action;
        if (burst_left == 0) burst_left = $urandom_range(1, 60);
        burst_left--;
        // a burst may end back to back with the next one
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern switches between several modes
  // ---------------------------------------------------------------------------
  int unsigned rdy_mode = 0;
  int unsigned rdy_left = 0;
  int unsigned rdy_phase = 0;

  always @(posedge clk_i) begin
    logic rdy_next;
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(20, 150);
    end
    rdy_left--;
    rdy_phase++;
    case (rdy_mode)
      0:       rdy_next = 1'b1;                          // never stalls
      1:       rdy_next = 1'($urandom_range(0, 1));      // coin toss
      2:       rdy_next = (rdy_phase % 4 == 0);          // ready when the phase is a multiple of four
      default: rdy_next = ($urandom_range(0, 15) == 0);  // long stalls
    endcase
    m_axis_tready <= rdy_next;
  end

  // ---------------------------------------------------------------------------
  // monitor: compare every accepted result with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lru_rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_rd >= expected_q.size()) begin
        $error("result item with no prediction pending: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = expected_q[exp_rd];
        exp_rd++;
        if (m_axis_tuser !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[5:0] !== want.victim) begin
          $error("victim_frame: expected %0d, got %0d", want.victim, m_axis_tdata[5:0]);
          errors++;
        end
        if (m_axis_tdata[12:6] !== want.count) begin
          $error("evictable_count: expected %0d, got %0d", want.count, m_axis_tdata[12:6]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles without any handshake
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned                    worked;
    int unsigned                    mode;
    int unsigned                    seg_len;
    int unsigned                    pick;
    int unsigned                    j;
    logic                           narrow;
    logic [lru_fr_pkg::FrameW-1:0]  base;
    logic [lru_fr_pkg::FrameW-1:0]  fr;
    logic [lru_fr_pkg::FrameW-1:0]  order [Frames];
    logic [lru_fr_pkg::FrameW-1:0]  tmp;
    logic [lru_fr_pkg::ActionW-1:0] act;

    // directed part
    queue_item(lru_fr_pkg::ActEvict, 6'd0);    // evict on an empty set
    queue_item(lru_fr_pkg::ActPin,   6'd0);    // pin of an absent frame
    queue_item(ActNop,               6'd63);   // undefined action code
    queue_item(lru_fr_pkg::ActUnpin, 6'd0);    // first frame into an empty set
    queue_item(lru_fr_pkg::ActUnpin, 6'd63);
    queue_item(lru_fr_pkg::ActUnpin, 6'd0);    // repeated unpin keeps the position
    queue_item(lru_fr_pkg::ActUnpin, 6'd42);
    queue_item(lru_fr_pkg::ActUnpin, 6'd21);
    queue_item(lru_fr_pkg::ActPin,   6'd63);   // pin from the middle
    queue_item(lru_fr_pkg::ActPin,   6'd21);   // pin of the newest frame
    queue_item(lru_fr_pkg::ActUnpin, 6'd63);
    queue_item(lru_fr_pkg::ActPin,   6'd0);    // pin of the oldest frame
    queue_item(lru_fr_pkg::ActEvict, 6'd63);   // frame field ignored on evict
    queue_item(lru_fr_pkg::ActEvict, 6'd0);
    queue_item(lru_fr_pkg::ActEvict, 6'd21);   // empty again
    queue_item(lru_fr_pkg::ActUnpin, 6'd63);
    queue_item(ActNop,               6'd0);
    queue_item(lru_fr_pkg::ActPin,   6'd63);   // pin of the only member
    queue_item(lru_fr_pkg::ActEvict, 6'd42);
    queue_item(lru_fr_pkg::ActUnpin, 6'd5);
    queue_item(lru_fr_pkg::ActUnpin, 6'd6);
    queue_item(lru_fr_pkg::ActEvict, 6'd0);
    queue_item(lru_fr_pkg::ActEvict, 6'd0);

    // random part in segments: fill, drain, mixed, or a full sweep of all frames
    worked = 0;
    while (worked < RandItems) begin
      mode    = $urandom_range(0, 9);
      seg_len = $urandom_range(10, 80);
      base    = lru_fr_pkg::FrameW'($urandom_range(0, Frames - 1));
      narrow  = 1'($urandom_range(0, 1));
      if (mode == 9) begin
        // unpin every frame in shuffled order, which fills the set completely
        for (int i = 0; i < Frames; i++) order[i] = lru_fr_pkg::FrameW'(i);
        for (int i = Frames - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < Frames; i++) queue_item(lru_fr_pkg::ActUnpin, order[i]);
        worked += Frames;
      end else begin
        for (int i = 0; i < seg_len; i++) begin
          pick = $urandom_range(0, 99);
          if (mode < 3) begin
            act = (pick < 80) ? lru_fr_pkg::ActUnpin : (pick < 90) ? lru_fr_pkg::ActPin :
                  (pick < 96) ? lru_fr_pkg::ActEvict : ActNop;
          end else if (mode < 6) begin
            act = (pick < 50) ? lru_fr_pkg::ActEvict : (pick < 85) ? lru_fr_pkg::ActPin :
                  (pick < 96) ? lru_fr_pkg::ActUnpin : ActNop;
          end else begin
            act = (pick < 30) ? lru_fr_pkg::ActEvict : (pick < 60) ? lru_fr_pkg::ActPin :
                  (pick < 96) ? lru_fr_pkg::ActUnpin : ActNop;
          end
          // a narrow window of frames makes pins and repeats hit members
          fr = narrow ? lru_fr_pkg::FrameW'(base + $urandom_range(0, 7))
                      : lru_fr_pkg::FrameW'($urandom_range(0, Frames - 1));
          queue_item(act, fr);
          if (act != ActNop) worked++;
        end
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait until all items are accepted and every prediction is compared
    do @(negedge clk_i);
    while (pend_rd < pending_q.size() || s_axis_tvalid || exp_rd < expected_q.size());
    repeat (DrainWait) @(negedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
